/* rtl/core/hap_pkg.sv */
// Shared constants, types and a helper function of the hex ARGB color parser.
package hap_pkg;

  localparam int MaxDigitsDefault = 32;

  localparam int StatusW  = 2;
  localparam int ConsumedW = 7;
  localparam int ArgbW    = 32;

  localparam logic [StatusW-1:0] StatusOk      = 2'd0;
  localparam logic [StatusW-1:0] StatusShort   = 2'd1;
  localparam logic [StatusW-1:0] StatusLong    = 2'd2;
  localparam logic [StatusW-1:0] StatusNoHash  = 2'd3;

  localparam logic [7:0] CharHash = 8'h23;

  localparam logic [3:0] NibbleFill = 4'hF;
  localparam logic [7:0] AlphaOpaque = 8'hFF;

  // Digit count with an alpha group that still uses three groups.
  localparam int ThreeGroupCount = 12;

  typedef struct packed {
    logic [ArgbW-1:0]     argb;
    logic [StatusW-1:0]   status;
    logic [ConsumedW-1:0] consumed;
  } result_t;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] nibble;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] ch);
    hex_digit_t d;
    d.is_hex = 1'b0;
    d.nibble = 4'd0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      d.is_hex = 1'b1;
      d.nibble = ch[3:0];
    end else if ((ch >= 8'h41 && ch <= 8'h46) || (ch >= 8'h61 && ch <= 8'h66)) begin
      d.is_hex = 1'b1;
      d.nibble = 4'(ch[2:0] + 3'd1) + 4'd8;
    end
    return d;
  endfunction

endpackage

/* rtl/core/hap_char_if.sv */
// Character input channel: valid/ready handshake with one string byte and a start mark.
interface hap_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       start_req;

  modport source (output valid, output character, output start_req, input ready);
  modport sink (input valid, input character, input start_req, output ready);
endinterface

/* rtl/core/hap_color_if.sv */
// Color result channel: valid/ready handshake with the ARGB word, status and count.
interface hap_color_if;
  logic                             valid;
  logic                             ready;
  logic [hap_pkg::ArgbW-1:0]        argb;
  logic [hap_pkg::StatusW-1:0]      status;
  logic [hap_pkg::ConsumedW-1:0]    consumed;

  modport source (output valid, output argb, output status, output consumed, input ready);
  modport sink (input valid, input argb, input status, input consumed, output ready);
endinterface

/* rtl/core/hex_argb_color_parser.sv */
// Top level of the hex ARGB color parser: input register, digit collection and result register.
//
// Takes one character per cycle on chars while colors is not stalled, and gives at most one
// ARGB result on colors for each string, on the non-hex character that ends its digits or on
// a start character that is not '#'. Every character passes through the input register, and a
// character that ends a string loads the result register from there once that register is
// free. A new character is taken in every cycle while colors keeps draining. The digits are
// not kept as a string: the leading digits of each group are written into a small set of
// lanes, one per possible group width, so the final word is assembled in the same cycle the
// terminating character is processed.
module hex_argb_color_parser #(
  parameter int MAX_DIGITS = hap_pkg::MaxDigitsDefault
) (
  input logic         clk,
  input logic         rst,
  hap_char_if.sink    chars,
  hap_color_if.source colors
);

  localparam int NumLanes = MAX_DIGITS / 3;
  localparam int CountW = $clog2(MAX_DIGITS + 1);
  localparam logic PhaseIdle = 1'b0;
  localparam logic PhaseCollect = 1'b1;

  logic                                in_valid;
  logic [7:0]                          in_char;
  logic                                in_start;
  logic                                phase;
  logic [CountW-1:0]                   count;
  logic                                overflowed;
  logic                                out_free;
  logic                                stage_go;
  logic                                emit;
  hap_pkg::result_t                    emit_result;
  hap_pkg::result_t                    finish_result;
  hap_pkg::hex_digit_t                 digit;
  logic                                digit_wr;
  logic [NumLanes-1:0][3:0][1:0][3:0]  lane_nib;

  assign out_free = !colors.valid || colors.ready;
  assign chars.ready = !in_valid || out_free;
  assign stage_go = in_valid && out_free;
  assign digit = hap_pkg::hex_decode(in_char);
  assign digit_wr = stage_go && !in_start && (phase == PhaseCollect) && digit.is_hex
                    && (count < CountW'(MAX_DIGITS));

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (chars.valid && chars.ready) begin
      in_valid <= 1'b1;
    end else if (stage_go) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      in_char <= chars.character;
      in_start <= chars.start_req;
    end
  end

  hap_digit_lanes #(.MAX_DIGITS(MAX_DIGITS)) u_lanes (
    .clk      (clk),
    .wr_en    (digit_wr),
    .wr_index (count),
    .wr_nibble(digit.nibble),
    .lane_nib (lane_nib)
  );

  hap_assemble #(.MAX_DIGITS(MAX_DIGITS)) u_assemble (
    .count     (count),
    .overflowed(overflowed),
    .lane_nib  (lane_nib),
    .result    (finish_result)
  );

  always_comb begin
    emit = 1'b0;
    emit_result = finish_result;
    if (in_start) begin
      emit = (in_char != hap_pkg::CharHash);
      emit_result.argb = '0;
      emit_result.status = hap_pkg::StatusNoHash;
      emit_result.consumed = '0;
    end else if (phase == PhaseCollect && !digit.is_hex) begin
      emit = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PhaseIdle;
      count <= '0;
      overflowed <= 1'b0;
    end else if (stage_go) begin
      if (in_start) begin
        count <= '0;
        overflowed <= 1'b0;
        phase <= (in_char == hap_pkg::CharHash) ? PhaseCollect : PhaseIdle;
      end else if (phase == PhaseCollect) begin
        if (digit.is_hex) begin
          if (count < CountW'(MAX_DIGITS)) begin
            count <= count + 1'b1;
          end else begin
            overflowed <= 1'b1;
          end
        end else begin
          phase <= PhaseIdle;
        end
      end
    end
  end

  // The result register is reloaded only on a transfer out or while it is empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      colors.valid <= 1'b0;
    end else if (stage_go && emit) begin
      colors.valid <= 1'b1;
    end else if (colors.ready) begin
      colors.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_go && emit) begin
      colors.argb <= emit_result.argb;
      colors.status <= emit_result.status;
      colors.consumed <= emit_result.consumed;
    end
  end

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CountW'(MAX_DIGITS))
    else $error("digit count above the store size");

  a_overflow_full : assert property (@(posedge clk) disable iff (rst)
    overflowed |-> (count == CountW'(MAX_DIGITS)))
    else $error("overflow flagged with room left in the store");

  a_error_zero : assert property (@(posedge clk) disable iff (rst)
    (colors.valid && colors.status != hap_pkg::StatusOk)
      |-> (colors.argb == '0 && colors.consumed == '0))
    else $error("error result carries a color or a count");

  a_ok_consumed : assert property (@(posedge clk) disable iff (rst)
    (colors.valid && colors.status == hap_pkg::StatusOk)
      |-> (colors.consumed >= 7'd4 && colors.consumed <= 7'(MAX_DIGITS + 1)))
    else $error("ok result with a consumed count out of range");

endmodule

/* rtl/core/hap_digit_lanes.sv */
// Digit capture lanes: one lane per group width, holding the two leading digits of each group.
module hap_digit_lanes #(
  parameter int MAX_DIGITS = hap_pkg::MaxDigitsDefault,
  localparam int NumLanes = MAX_DIGITS / 3,
  localparam int CountW = $clog2(MAX_DIGITS + 1)
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [CountW-1:0]                    wr_index,
  input  logic [3:0]                           wr_nibble,
  output logic [NumLanes-1:0][3:0][1:0][3:0]   lane_nib
);

  // Lane l serves group width l+1; slot (j, d) holds digit j*(l+1)+d.
  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    for (genvar j = 0; j < 4; j++) begin : g_group
      for (genvar d = 0; d < 2; d++) begin : g_digit
        always_ff @(posedge clk) begin
          if (wr_en && (int'(wr_index) == j * (l + 1) + d)) begin
            lane_nib[l][j][d] <= wr_nibble;
          end
        end
      end
    end
  end

endmodule

/* rtl/core/hap_assemble.sv */
// Result assembly: picks the lane for the final group width and packs the ARGB word.
module hap_assemble #(
  parameter int MAX_DIGITS = hap_pkg::MaxDigitsDefault,
  localparam int NumLanes = MAX_DIGITS / 3,
  localparam int LaneW = $clog2(NumLanes),
  localparam int CountW = $clog2(MAX_DIGITS + 1)
) (
  input  logic [CountW-1:0]                    count,
  input  logic                                 overflowed,
  input  logic [NumLanes-1:0][3:0][1:0][3:0]   lane_nib,
  output hap_pkg::result_t                     result
);

  logic [15:0]                 third_prod;
  logic [6:0]                  n_ext;
  logic [6:0]                  group_w;
  logic                        has_alpha;
  logic                        single;
  logic [LaneW-1:0]            lane_sel;
  logic [3:0][1:0][3:0]        lane;
  logic [1:0]                  base;
  logic [7:0]                  alpha;
  logic [7:0]                  red;
  logic [7:0]                  green;
  logic [7:0]                  blue;
  logic [6:0]                  used;

  assign n_ext = 7'(count);
  // n/3 as n*171 >> 9, exact for every count below 512.
  assign third_prod = 16'(n_ext) * 16'd171;
  assign has_alpha = (n_ext[1:0] == 2'd0) && (n_ext != 7'(hap_pkg::ThreeGroupCount));
  assign group_w = has_alpha ? (n_ext >> 2) : third_prod[15:9];
  assign single = (group_w == 7'd1);
  assign lane_sel = LaneW'(group_w - 7'd1);
  assign lane = lane_nib[lane_sel];
  assign base = has_alpha ? 2'd1 : 2'd0;

  always_comb begin
    alpha = has_alpha ? {lane[0][0], single ? hap_pkg::NibbleFill : lane[0][1]}
                      : hap_pkg::AlphaOpaque;
    red   = {lane[base][0], single ? hap_pkg::NibbleFill : lane[base][1]};
    green = {lane[base + 2'd1][0], single ? hap_pkg::NibbleFill : lane[base + 2'd1][1]};
    blue  = {lane[base + 2'd2][0], single ? hap_pkg::NibbleFill : lane[base + 2'd2][1]};
    used  = has_alpha ? 7'(7'd1 + (group_w << 2)) : 7'(7'd1 + group_w + (group_w << 1));
  end

  always_comb begin
    result.argb = '0;
    result.consumed = '0;
    if (overflowed) begin
      result.status = hap_pkg::StatusLong;
    end else if (n_ext < 7'd3) begin
      result.status = hap_pkg::StatusShort;
    end else begin
      result.status = hap_pkg::StatusOk;
      result.argb = {alpha, red, green, blue};
      result.consumed = used;
    end
  end

endmodule

/* dv/tb_hex_argb_color_parser.sv */
// Self-checking testbench for the hex ARGB color parser: character stimulus and result checks.
module tb_hex_argb_color_parser;

  localparam int MaxDigits = hap_pkg::MaxDigitsDefault;
  localparam int ItemGoal = 900;
  localparam int SteadyItems = 150;
  localparam int SettleCycles = 8;
  localparam int QuietLimit = 1000;
  localparam int LongStall = 80;

  localparam logic [7:0] CharNul = 8'h00;
  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharNine = 8'h39;
  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharUpperF = 8'h46;
  localparam logic [7:0] CharLowerA = 8'h61;
  localparam logic [7:0] CharLowerF = 8'h66;

  typedef enum logic {ParseIdle, ParseDigits} parse_phase_e;

  logic clk;
  logic rst;

  hap_char_if chars_if ();
  hap_color_if colors_if ();

  hex_argb_color_parser #(
    .MAX_DIGITS(MaxDigits)
  ) dut (
    .clk(clk),
    .rst(rst),
    .chars(chars_if),
    .colors(colors_if)
  );

  // Parser state as the block should hold it.
  parse_phase_e parse_phase;
  int unsigned digit_total;
  bit digit_overflow;
  logic [3:0] nibbles [MaxDigits];

  hap_pkg::result_t expected_colors [$];
  hap_pkg::result_t want;

  int error_count;
  int chars_counted;
  int colors_seen;
  int status_seen [4];
  int quiet_cycles;

  bit src_idle_on;
  bit sink_idle_on;
  int result_stall_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit decode_hex_char(input logic [7:0] ch, output logic [3:0] value);
    value = 4'd0;
    if (ch >= CharZero && ch <= CharNine) begin
      value = 4'(ch - CharZero);
      return 1'b1;
    end
    if (ch >= CharUpperA && ch <= CharUpperF) begin
      value = 4'(ch - CharUpperA + 8'd10);
      return 1'b1;
    end
    if (ch >= CharLowerA && ch <= CharLowerF) begin
      value = 4'(ch - CharLowerA + 8'd10);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic hap_pkg::result_t assemble_color();
    hap_pkg::result_t r;
    int n;
    int g;
    int pos;
    r = '0;
    n = digit_total;
    if (digit_overflow) begin
      r.status = hap_pkg::StatusLong;
    end else if (n < 3) begin
      r.status = hap_pkg::StatusShort;
    end else begin
      r.status = hap_pkg::StatusOk;
      if (n % 4 == 0 && n != hap_pkg::ThreeGroupCount) begin
        g = n / 4;
        r.argb[31:28] = nibbles[0];
        r.argb[27:24] = (g > 1) ? nibbles[1] : hap_pkg::NibbleFill;
        pos = g;
        r.consumed = hap_pkg::ConsumedW'(1 + 4 * g);
      end else begin
        g = n / 3;
        r.argb[31:24] = hap_pkg::AlphaOpaque;
        pos = 0;
        r.consumed = hap_pkg::ConsumedW'(1 + 3 * g);
      end
      // A one-digit group puts its digit in the high nibble of its channel and fills the low nibble with F.
      for (int c = 0; c < 3; c++) begin
        r.argb[23 - 8 * c -: 4] = nibbles[pos + c * g];
        r.argb[19 - 8 * c -: 4] = (g > 1) ? nibbles[pos + c * g + 1] : hap_pkg::NibbleFill;
      end
    end
    return r;
  endfunction

  function automatic bit parse_char(input logic [7:0] ch, input logic st,
                                    output hap_pkg::result_t r);
    logic [3:0] value;
    r = '0;
    if (st) begin
      digit_total = 0;
      digit_overflow = 1'b0;
      if (ch == hap_pkg::CharHash) begin
        parse_phase = ParseDigits;
        return 1'b0;
      end
      parse_phase = ParseIdle;
      r.status = hap_pkg::StatusNoHash;
      return 1'b1;
    end
    if (parse_phase != ParseDigits) return 1'b0;
    if (decode_hex_char(ch, value)) begin
      if (digit_total < MaxDigits) begin
        nibbles[digit_total] = value;
        digit_total++;
      end else begin
        digit_overflow = 1'b1;
      end
      return 1'b0;
    end
    r = assemble_color();
    parse_phase = ParseIdle;
    return 1'b1;
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] value);
    if (value < 4'd10) return CharZero + value;
    return ($urandom_range(0, 1) ? CharLowerA : CharUpperA) + (value - 4'd10);
  endfunction

  function automatic logic [7:0] random_non_hex();
    logic [7:0] b;
    logic [3:0] value;
    do b = 8'($urandom_range(0, 255)); while (decode_hex_char(b, value));
    return b;
  endfunction

  function automatic logic [7:0] random_terminator();
    return ($urandom_range(0, 5) == 0) ? CharNul : random_non_hex();
  endfunction

  function automatic logic [7:0] random_bad_start();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == hap_pkg::CharHash);
    return b;
  endfunction

  function automatic int pick_digit_count();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 6) return $urandom_range(0, 12);
    if (roll < 9) return $urandom_range(13, MaxDigits);
    return $urandom_range(MaxDigits + 1, MaxDigits + 8);
  endfunction

  task automatic send_char(input logic [7:0] ch, input logic st);
    int gap;
    hap_pkg::result_t r;
    gap = (src_idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 9) : 0;
    @(negedge clk);
    if (gap > 0) begin
      chars_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    chars_if.valid <= 1'b1;
    chars_if.character <= ch;
    chars_if.start_req <= st;
    do @(posedge clk); while (!chars_if.ready);
    if (st || parse_phase == ParseDigits) chars_counted++;
    if (parse_char(ch, st, r)) expected_colors.push_back(r);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == 0);
  endtask

  task automatic send_digits(input int n);
    repeat (n) send_char(digit_char(4'($urandom_range(0, 15))), 1'b0);
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    chars_if.valid <= 1'b0;
    while (expected_colors.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic test_directed_cases();
    send_char(8'h78, 1'b1);
    send_char(CharNul, 1'b1);
    send_char(hap_pkg::CharHash, 1'b1);
    send_char(CharNul, 1'b0);
    // Unmarked characters while idle must be dropped silently.
    send_char(8'h35, 1'b0);
    send_char(hap_pkg::CharHash, 1'b0);
    send_text("#f0a");
    send_char(8'hFF, 1'b0);
    send_text("#1234");
    send_char(8'h67, 1'b0);
    send_text("#12");
    send_text("#ABCdef");
    send_char(hap_pkg::CharHash, 1'b0);
    send_text("#89");
    send_char(8'h2F, 1'b0);
    send_text("#0F9");
    send_char(8'h3A, 1'b0);
    wait_results_drained();
  endtask

  task automatic test_result_backpressure();
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    result_stall_cycles = LongStall;
    repeat (12) begin
      send_char(hap_pkg::CharHash, 1'b1);
      send_digits(3);
      send_char(random_non_hex(), 1'b0);
    end
    wait_results_drained();
  endtask

  task automatic test_random_strings(input int goal, input bit with_idling);
    int forced [$];
    int kind;
    forced = '{hap_pkg::ThreeGroupCount, MaxDigits, MaxDigits + 1, 4, 3};
    src_idle_on = with_idling;
    sink_idle_on = with_idling;
    while (chars_counted < goal) begin
      if (with_idling && $urandom_range(0, 11) == 0) begin
        src_idle_on = $urandom_range(0, 1);
        sink_idle_on = $urandom_range(0, 1);
      end
      kind = (forced.size() != 0) ? 3 : $urandom_range(0, 19);
      case (kind)
        0: send_char(random_bad_start(), 1'b1);
        1: begin
          repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(0, 255)), 1'b0);
        end
        2: begin
          // Left unfinished so that the next start mark drops it.
          send_char(hap_pkg::CharHash, 1'b1);
          send_digits($urandom_range(0, 8));
        end
        default: begin
          send_char(hap_pkg::CharHash, 1'b1);
          send_digits((forced.size() != 0) ? forced.pop_front() : pick_digit_count());
          send_char(random_terminator(), 1'b0);
        end
      endcase
    end
    wait_results_drained();
  endtask

  initial begin : color_sink
    int hold;
    colors_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (result_stall_cycles > 0) begin
        hold = result_stall_cycles;
        result_stall_cycles = 0;
        colors_if.ready <= 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 9);
        colors_if.ready <= 1'b0;
      end else begin
        hold = 1;
        colors_if.ready <= 1'b1;
      end
      repeat (hold - 1) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && colors_if.valid && colors_if.ready) begin
      colors_seen++;
      if (expected_colors.size() == 0) begin
        $display("%0t: result with none expected: argb %h status %0d consumed %0d",
                 $time, colors_if.argb, colors_if.status, colors_if.consumed);
        error_count++;
      end else begin
        want = expected_colors.pop_front();
        if (colors_if.argb !== want.argb) begin
          $display("%0t: argb mismatch, expected %h, actual %h", $time, want.argb,
                   colors_if.argb);
          error_count++;
        end
        if (colors_if.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d", $time, want.status,
                   colors_if.status);
          error_count++;
        end
        if (colors_if.consumed !== want.consumed) begin
          $display("%0t: consumed mismatch, expected %0d, actual %0d", $time,
                   want.consumed, colors_if.consumed);
          error_count++;
        end
        status_seen[want.status]++;
      end
    end
  end

  // Any stretch this long without a transfer on either channel means the block hung.
  always @(posedge clk) begin
    if (rst || (chars_if.valid && chars_if.ready) || (colors_if.valid && colors_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
               QuietLimit, expected_colors.size());
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    chars_if.valid = 1'b0;
    chars_if.character = 8'h00;
    chars_if.start_req = 1'b0;
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
    result_stall_cycles = 0;
    error_count = 0;
    chars_counted = 0;
    colors_seen = 0;
    quiet_cycles = 0;
    parse_phase = ParseIdle;
    digit_total = 0;
    digit_overflow = 1'b0;
    foreach (nibbles[i]) nibbles[i] = 4'd0;
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_result_backpressure();
    test_random_strings(ItemGoal - SteadyItems, 1'b1);
    test_random_strings(ItemGoal, 1'b0);

    repeat (SettleCycles) @(posedge clk);
    if (expected_colors.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_colors.size());
      error_count++;
    end
    $display("Run covered %0d parsed characters and %0d results, with stalls on both sides.",
             chars_counted, colors_seen);
    $display("Results by status: %0d ok, %0d too short, %0d too long, %0d missing hash.",
             status_seen[hap_pkg::StatusOk], status_seen[hap_pkg::StatusShort],
             status_seen[hap_pkg::StatusLong], status_seen[hap_pkg::StatusNoHash]);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
